// ----- rtl/rlcm_pkg.sv -----
`default_nettype none

package rlcm_pkg;

  typedef logic [1:0] lcm_status_t;

  localparam lcm_status_t ST_OK       = 2'd0;
  localparam lcm_status_t ST_OVERFLOW = 2'd1;
  localparam lcm_status_t ST_ZERO     = 2'd2;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic mul_init;
    logic mul_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic gcd_done;
    logic cnt_zero;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/rlcm_dp.sv -----
`default_nettype none

module rlcm_dp
  import rlcm_pkg::*;
#(
  parameter int RESULT_WIDTH = 48,
  parameter int PERIOD_WIDTH = 31
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [RESULT_WIDTH-1:0] cfg_wdata,
  input  wire logic [PERIOD_WIDTH-1:0] in_period,
  input  wire logic                    in_last,
  input  wire dp_cmd_t                 cmd,
  output dp_stat_t                     stat,
  output logic [RESULT_WIDTH-1:0]      out_interval,
  output logic [1:0]                   out_status,
  output logic                         out_final_res
);

  localparam int RW = RESULT_WIDTH;
  localparam int PW = PERIOD_WIDTH;
  localparam int GW = (RW > PW) ? RW : PW;
  localparam int KW = $clog2(GW);
  localparam int AW = RW + PW;
  localparam int CW = $clog2(PW + 1);

  logic [RW-1:0] limit_r;
  logic [RW-1:0] run_r;
  lcm_status_t   sticky_r;
  logic [PW-1:0] per_r;
  logic          last_r;
  logic [GW-1:0] a_r;
  logic [GW-1:0] b_r;
  logic [KW-1:0] k_r;
  logic [PW-1:0] g_r;
  logic [PW-1:0] rem_r;
  logic [PW-1:0] dq_r;
  logic [AW-1:0] acc_r;
  logic [CW-1:0] cnt_r;
  logic [RW-1:0] out_interval_r;
  lcm_status_t   out_status_r;
  logic          out_final_r;

  logic [GW-1:0] g_wide;
  logic [PW:0]   rem_sh;
  logic [PW:0]   rem_diff;
  logic          rem_ge;
  logic [AW-1:0] addend;
  logic          ovf;
  lcm_status_t   sticky_nxt;
  logic [RW-1:0] run_nxt;

  assign stat.skip     = (sticky_r != ST_OK) || (per_r == '0);
  assign stat.gcd_done = (a_r == b_r);
  assign stat.cnt_zero = (cnt_r == '0);

  assign g_wide   = a_r << k_r;
  assign rem_sh   = {rem_r, dq_r[PW-1]};
  assign rem_diff = rem_sh - {1'b0, g_r};
  assign rem_ge   = (rem_sh >= {1'b0, g_r});
  assign addend   = dq_r[PW-1] ? AW'(run_r) : '0;
  assign ovf      = (acc_r > AW'(limit_r));

  always_comb begin
    sticky_nxt = sticky_r;
    run_nxt    = run_r;
    if (sticky_r == ST_OK) begin
      if (per_r == '0) begin
        sticky_nxt = ST_ZERO;
      end else if (ovf) begin
        sticky_nxt = ST_OVERFLOW;
      end else begin
        run_nxt = acc_r[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= '1;
      run_r    <= RW'(1);
      sticky_r <= ST_OK;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.finish) begin
        if (last_r) begin
          run_r    <= RW'(1);
          sticky_r <= ST_OK;
        end else begin
          run_r    <= run_nxt;
          sticky_r <= sticky_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      per_r  <= in_period;
      last_r <= in_last;
      a_r    <= GW'(run_r);
      b_r    <= GW'(in_period);
      k_r    <= '0;
    end else if (cmd.gcd_step) begin
      case ({a_r[0], b_r[0]})
        2'b00: begin
          a_r <= a_r >> 1;
          b_r <= b_r >> 1;
          k_r <= k_r + KW'(1);
        end
        2'b01: begin
          a_r <= a_r >> 1;
        end
        2'b10: begin
          b_r <= b_r >> 1;
        end
        default: begin
          if (a_r > b_r) begin
            a_r <= (a_r - b_r) >> 1;
          end else begin
            b_r <= (b_r - a_r) >> 1;
          end
        end
      endcase
    end
    if (cmd.div_init) begin
      g_r   <= g_wide[PW-1:0];
      rem_r <= '0;
      dq_r  <= per_r;
      cnt_r <= CW'(PW);
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_diff[PW-1:0] : rem_sh[PW-1:0];
      dq_r  <= {dq_r[PW-2:0], rem_ge};
      cnt_r <= cnt_r - CW'(1);
    end else if (cmd.mul_init) begin
      acc_r <= '0;
      cnt_r <= CW'(PW);
    end else if (cmd.mul_step) begin
      acc_r <= {acc_r[AW-2:0], 1'b0} + addend;
      dq_r  <= {dq_r[PW-2:0], 1'b0};
      cnt_r <= cnt_r - CW'(1);
    end
    if (cmd.finish) begin
      out_interval_r <= (sticky_nxt == ST_OK) ? run_nxt : '0;
      out_status_r   <= sticky_nxt;
      out_final_r    <= last_r;
    end
  end

  assign out_interval  = out_interval_r;
  assign out_status    = out_status_r;
  assign out_final_res = out_final_r;

endmodule

`default_nettype wire

// ----- rtl/rlcm_ctrl.sv -----
`default_nettype none

module rlcm_ctrl
  import rlcm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.skip) begin
          state_nxt = S_FIN;
        end else if (stat.gcd_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        if (stat.cnt_zero) begin
          cmd.mul_init = 1'b1;
          state_nxt    = S_MUL;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_MUL: begin
        if (stat.cnt_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_FIN: begin
        if (!(out_valid_r && out_stall)) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/running_lcm_with_limit.sv -----
`default_nettype none

// Running least common multiple with an overflow limit. Each accepted beat
// folds one period into a running multiple that starts at 1 and gives one
// result beat with the new value (zero while an error is held) and a status;
// an overflow or a zero period sticks until the beat marked last, after
// which the block starts over at 1. An item runs binary gcd steps, then one
// bit a cycle of a restoring divider and of a shift-add multiplier; an item
// that meets a held error goes from the gcd state straight to the finish
// state. The next beat is accepted as soon as the result sits in the output
// register, and the limit may be written only while the block is idle.
module running_lcm_with_limit
  import rlcm_pkg::*;
#(
  parameter int RESULT_WIDTH = 48,
  parameter int PERIOD_WIDTH = 31
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [RESULT_WIDTH-1:0] cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [PERIOD_WIDTH-1:0] in_period,
  input  wire logic                    in_last,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [RESULT_WIDTH-1:0]      out_interval,
  output logic [1:0]                   out_status,
  output logic                         out_final_res
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rlcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rlcm_dp #(
    .RESULT_WIDTH (RESULT_WIDTH),
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_period     (in_period),
    .in_last       (in_last),
    .cmd           (cmd),
    .stat          (stat),
    .out_interval  (out_interval),
    .out_status    (out_status),
    .out_final_res (out_final_res)
  );

endmodule

`default_nettype wire

// ----- sim/running_lcm_with_limit_test.sv -----
`timescale 1ns / 1ps

module running_lcm_with_limit_test;
  import rlcm_pkg::*;

  localparam int RW = 48;
  localparam int PW = 31;
  localparam int QUIET_LIMIT = 5000;

  typedef struct {
    logic [RW-1:0] interval;
    lcm_status_t   status;
    logic          final_res;
  } lcm_beat_t;

  class lcm_predictor;
    logic [RW-1:0] limit;
    logic [RW-1:0] multiple;
    lcm_status_t   held;
    lcm_beat_t     pending_lcms[$];
    int            failures;

    function new();
      limit = '1;
      multiple = RW'(1);
      held = ST_OK;
      failures = 0;
    endfunction

    function void fold_period(logic [PW-1:0] period, logic last);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] t;
      logic [63:0] reduced;
      lcm_beat_t beat;
      if (held == ST_OK) begin
        if (period == '0) begin
          held = ST_ZERO;
        end else begin
          a = 64'(multiple);
          b = 64'(period);
          while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
          end
          reduced = 64'(multiple);
          reduced = reduced / a;
          t = 64'(limit);
          b = 64'(period);
          if (reduced > t / b) begin
            held = ST_OVERFLOW;
          end else begin
            t = reduced * b;
            multiple = t[RW-1:0];
          end
        end
      end
      beat.interval = (held == ST_OK) ? multiple : '0;
      beat.status = held;
      beat.final_res = last;
      pending_lcms.push_back(beat);
      if (last) begin
        multiple = RW'(1);
        held = ST_OK;
      end
    endfunction

    function void check_result(logic [RW-1:0] interval, lcm_status_t status, logic final_res);
      lcm_beat_t beat;
      if (pending_lcms.size() == 0) begin
        $error("result beat with nothing expected: interval %0d status %0d final_res %0b",
               interval, status, final_res);
        failures++;
        return;
      end
      beat = pending_lcms.pop_front();
      if (interval !== beat.interval) begin
        $error("interval: expected %0d, got %0d", beat.interval, interval);
        failures++;
      end
      if (status !== beat.status) begin
        $error("status: expected %0d, got %0d", beat.status, status);
        failures++;
      end
      if (final_res !== beat.final_res) begin
        $error("final_res: expected %0b, got %0b", beat.final_res, final_res);
        failures++;
      end
    endfunction

    function int pending();
      return pending_lcms.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic [RW-1:0] cfg_wdata = '0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [PW-1:0] in_period = '0;
  logic          in_last = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [RW-1:0] out_interval;
  logic [1:0]    out_status;
  logic          out_final_res;

  lcm_predictor lcm_model = new();
  bit           no_idle = 1'b0;
  int           periods_sent = 0;
  int           quiet_cycles = 0;

  running_lcm_with_limit #(
    .RESULT_WIDTH(RW),
    .PERIOD_WIDTH(PW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_period(in_period),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_interval(out_interval),
    .out_status(out_status),
    .out_final_res(out_final_res)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        lcm_model.fold_period(in_period, in_last);
      end
      if (out_valid && !out_stall) begin
        lcm_model.check_result(out_interval, out_status, out_final_res);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int stall_for;
    forever begin
      stall_for = no_idle ? 0 : $urandom_range(0, 19);
      if (stall_for > 0) begin
        out_stall <= 1'b1;
        repeat (stall_for) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_period(input logic [PW-1:0] period, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_period <= period;
    in_last <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (lcm_model.pending() != 0);
  endtask

  task automatic write_limit(input logic [RW-1:0] value);
    wait_for_results();
    repeat (3) @(negedge clk);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    lcm_model.limit = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_set(input bit noisy);
    int len;
    int pick;
    logic [PW-1:0] period;
    logic last;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        period = '0;
      end else if (pick < 15) begin
        period = PW'($urandom);
      end else if (pick < 30) begin
        period = PW'($urandom_range(1, 1000));
      end else begin
        period = PW'($urandom_range(1, 64));
      end
      last = noisy ? 1'($urandom_range(0, 1)) : (i == len - 1);
      send_period(period, last);
      periods_sent++;
    end
  endtask

  initial begin
    logic [RW-1:0] phase_limits[7];
    phase_limits[0] = '1;
    phase_limits[1] = 48'd1000;
    phase_limits[2] = RW'({$urandom, $urandom});
    phase_limits[3] = 48'hFFFF_FFFF;
    phase_limits[4] = 48'd1;
    phase_limits[5] = RW'($urandom_range(1, 1 << 20));
    phase_limits[6] = '1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extremes of the period, overflow, a held error and zero periods.
    send_period(31'd1, 1'b0);
    send_period('1, 1'b0);
    send_period('1, 1'b0);
    send_period(31'h7FFF_FFFE, 1'b0);
    send_period(31'd5, 1'b1);
    send_period('0, 1'b0);
    send_period(31'd3, 1'b1);
    send_period('0, 1'b1);
    send_period(31'd12, 1'b0);
    send_period(31'd18, 1'b1);

    write_limit('0);
    send_period(31'd1, 1'b0);
    send_period(31'd7, 1'b1);

    // The limit drops below the multiple already held in an open set.
    write_limit('1);
    send_period(31'd6, 1'b0);
    send_period(31'd10, 1'b0);
    write_limit(48'd20);
    send_period(31'd3, 1'b1);

    write_limit(48'd1);
    send_period(31'd1, 1'b0);
    send_period(31'd2, 1'b1);

    write_limit(48'h7FFF_FFFF);
    send_period('1, 1'b0);
    send_period(31'd2, 1'b1);

    periods_sent = 0;
    for (int ph = 0; ph < 7; ph++) begin
      write_limit(phase_limits[ph]);
      no_idle = (ph == 2 || ph == 5);
      while (periods_sent < (ph + 1) * 100) begin
        if ($urandom_range(0, 39) == 0) begin
          wait_for_results();
        end
        send_set($urandom_range(0, 9) == 0);
      end
    end
    no_idle = 1'b0;

    wait_for_results();
    repeat (200) @(negedge clk);
    if (lcm_model.pending() != 0) begin
      $error("%0d expected result beats never arrived", lcm_model.pending());
      lcm_model.failures++;
    end
    if (lcm_model.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
